@@ hw/rtl/qalu_pkg.sv @@
// shared types and constants of the q24.8 fixed-point alu
package qalu_pkg;

    localparam int W      = 32;            // word width
    localparam int F      = 8;             // fraction bits
    localparam int NB     = W + F;         // dividend width after the fraction shift
    localparam int DSTEPS = 2;             // quotient bits per divider stage
    localparam int DSTG   = NB / DSTEPS;   // divider stages
    localparam int NSTG   = DSTG + 2;      // decode, multiply, divider stages
    localparam int MB     = 2 * W - F + 1; // widest magnitude before saturation

    localparam logic [3:0] K_ADD   = 4'd0;
    localparam logic [3:0] K_SUB   = 4'd1;
    localparam logic [3:0] K_MUL   = 4'd2;
    localparam logic [3:0] K_DIV   = 4'd3;
    localparam logic [3:0] K_MIN   = 4'd4;
    localparam logic [3:0] K_MAX   = 4'd5;
    localparam logic [3:0] K_INC   = 4'd6;
    localparam logic [3:0] K_DEC   = 4'd7;
    localparam logic [3:0] K_INT   = 4'd8;
    localparam logic [3:0] K_TOFIX = 4'd9;

    // one transaction as it moves down the pipeline
    typedef struct packed {
        logic [3:0]     kind;
        logic [W-1:0]   ra;
        logic [W-1:0]   rb;
        logic           na;
        logic           nb;
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic           gt;
        logic           lt;
        logic           eq;
        logic [2*W-1:0] prod;
        logic [W-1:0]   rem;
        logic [NB-1:0]  num;
    } t_item;

    // finished result
    typedef struct packed {
        logic [W-1:0] value;
        logic         gt;
        logic         lt;
        logic         eq;
        logic         ov;
        logic         dz;
    } t_res;

endpackage

@@ hw/rtl/qalu_if.sv @@
// valid/ready channels of the q24.8 fixed-point alu
interface qalu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface qalu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        a_greater;
    logic        a_less;
    logic        a_equal;
    logic        overflow;
    logic        divide_by_zero;

    modport source (output valid, value, a_greater, a_less, a_equal, overflow,
                    divide_by_zero, input ready);
    modport sink   (input valid, value, a_greater, a_less, a_equal, overflow,
                    divide_by_zero, output ready);
endinterface

@@ hw/rtl/qalu_decode.sv @@
// operand decode: magnitudes, signs, compare flags, divider setup
module qalu_decode (
    input  logic [3:0]           i_kind,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output qalu_pkg::t_item      o_itm
);
    import qalu_pkg::*;

    // split into sign and magnitude, compare as signed words
    always_comb begin
        o_itm      = '0;
        o_itm.kind = i_kind;
        o_itm.ra   = i_a;
        o_itm.rb   = i_b;
        o_itm.na   = i_a[W-1];
        o_itm.nb   = i_b[W-1];
        o_itm.ma   = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        o_itm.mb   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        o_itm.gt   = $signed(i_a) > $signed(i_b);
        o_itm.lt   = $signed(i_a) < $signed(i_b);
        o_itm.eq   = i_a == i_b;
        o_itm.num  = {o_itm.ma, {F{1'b0}}};
    end
endmodule

@@ hw/rtl/qalu_mul.sv @@
// magnitude multiply
module qalu_mul (
    input  qalu_pkg::t_item i_itm,
    output qalu_pkg::t_item o_itm
);
    import qalu_pkg::*;

    // full-width product of the magnitudes
    always_comb begin
        o_itm      = i_itm;
        o_itm.prod = {{W{1'b0}}, i_itm.ma} * {{W{1'b0}}, i_itm.mb};
    end
endmodule

@@ hw/rtl/qalu_div_step.sv @@
// restoring divider slice, DSTEPS quotient bits
module qalu_div_step (
    input  qalu_pkg::t_item i_itm,
    output qalu_pkg::t_item o_itm
);
    import qalu_pkg::*;

    logic [W:0]    t;
    logic [W-1:0]  rem;
    logic [NB-1:0] num;
    logic          q;

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        rem = i_itm.rem;
        num = i_itm.num;
        t   = '0;
        q   = 1'b0;
        for (int j = 0; j < DSTEPS; j++) begin
            t = {rem, num[NB-1]};
            q = t >= {1'b0, i_itm.mb};
            if (q) begin
                rem = W'(t - {1'b0, i_itm.mb});
            end else begin
                rem = t[W-1:0];
            end
            num = {num[NB-2:0], q};
        end
        o_itm     = i_itm;
        o_itm.rem = rem;
        o_itm.num = num;
    end
endmodule

@@ hw/rtl/qalu_round.sv @@
// rounding, saturation and result select
module qalu_round (
    input  qalu_pkg::t_item i_itm,
    output qalu_pkg::t_res  o_res
);
    import qalu_pkg::*;

    localparam logic [MB-1:0] POS_LIM = MB'({1'b0, {(W-1){1'b1}}});
    localparam logic [MB-1:0] NEG_LIM = MB'({1'b1, {(W-1){1'b0}}});
    localparam logic [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};

    logic [2*W:0]   prnd;
    logic           qrnd;
    logic [NB:0]    quo;
    logic [W+1:0]   sum;
    logic [MB-1:0]  mag;
    logic           neg;
    logic [W-1:0]   sat_val;
    logic           sat_ov;
    logic           sum_ov;
    logic [W-1:0]   sum_val;
    logic [W-1:0]   ipart;

    // rounded magnitudes: product and quotient, half away from zero
    always_comb begin
        prnd = {1'b0, i_itm.prod} + (2*W+1)'(1 << (F-1));
        qrnd = {i_itm.rem, 1'b0} >= {1'b0, i_itm.mb};
        quo  = {1'b0, i_itm.num} + (NB+1)'(qrnd);
    end

    // signed add path for add, sub, inc, dec
    always_comb begin
        case (i_itm.kind)
            K_ADD:   sum = {{2{i_itm.ra[W-1]}}, i_itm.ra} + {{2{i_itm.rb[W-1]}}, i_itm.rb};
            K_SUB:   sum = {{2{i_itm.ra[W-1]}}, i_itm.ra} - {{2{i_itm.rb[W-1]}}, i_itm.rb};
            K_INC:   sum = {{2{i_itm.ra[W-1]}}, i_itm.ra} + (W+2)'(1);
            default: sum = {{2{i_itm.ra[W-1]}}, i_itm.ra} - (W+2)'(1);
        endcase
        sum_ov  = !((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111));
        sum_val = sum_ov ? (sum[W+1] ? WMIN : WMAX) : sum[W-1:0];
    end

    // sign-magnitude path for mul, div, to-fixed
    always_comb begin
        case (i_itm.kind)
            K_MUL: begin
                neg = i_itm.na ^ i_itm.nb;
                mag = prnd[2*W:F];
            end
            K_DIV: begin
                neg = i_itm.na ^ i_itm.nb;
                mag = MB'(quo);
            end
            default: begin
                neg = i_itm.na;
                mag = MB'({i_itm.ma, {F{1'b0}}});
            end
        endcase
        if (neg) begin
            sat_ov  = mag > NEG_LIM;
            sat_val = sat_ov ? WMIN : (~mag[W-1:0] + 1'b1);
        end else begin
            sat_ov  = mag > POS_LIM;
            sat_val = sat_ov ? WMAX : mag[W-1:0];
        end
    end

    // integer part truncated toward zero
    always_comb begin
        ipart = W'(i_itm.ma >> F);
        if (i_itm.na) begin
            ipart = ~ipart + 1'b1;
        end
    end

    // result select
    always_comb begin
        o_res    = '0;
        o_res.gt = i_itm.gt;
        o_res.lt = i_itm.lt;
        o_res.eq = i_itm.eq;
        case (i_itm.kind) inside
            K_ADD, K_SUB, K_INC, K_DEC: begin
                o_res.value = sum_val;
                o_res.ov    = sum_ov;
            end
            K_MUL, K_TOFIX: begin
                o_res.value = sat_val;
                o_res.ov    = sat_ov;
            end
            K_DIV: begin
                if (i_itm.mb == '0) begin
                    o_res.value = i_itm.na ? WMIN : WMAX;
                    o_res.dz    = 1'b1;
                end else begin
                    o_res.value = sat_val;
                    o_res.ov    = sat_ov;
                end
            end
            K_MIN:   o_res.value = i_itm.lt ? i_itm.ra : i_itm.rb;
            K_MAX:   o_res.value = i_itm.gt ? i_itm.ra : i_itm.rb;
            K_INT:   o_res.value = ipart;
            default: o_res.value = '0;
        endcase
    end
endmodule

@@ hw/rtl/q24_8_fixed_point_alu.sv @@
// Q24.8 fixed-point alu: add, sub, mul, div, min, max, inc, dec, integer
// part and integer-to-fixed, with compare flags on every transaction.
// Fully pipelined: one transaction per cycle while the output is not held,
// through 23 register stages (decode, multiply, 20 divider stages of two
// quotient bits each, then round/saturate into the output register). The
// accepting edge loads the first stage. Every operation takes the same path
// length, so results leave in input order.
// Each stage holds its own valid bit and moves forward whenever the next
// stage is empty or moving, so bubbles close up under output backpressure.
module q24_8_fixed_point_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qalu_in_if.sink    i_in,
    qalu_out_if.source o_out
);
    import qalu_pkg::*;

    logic [NSTG-1:0] r_vld;
    t_item           r_itm [NSTG];
    t_item           n_itm [NSTG];
    logic            r_out_vld;
    t_res            r_out;
    t_res            n_res;
    logic [NSTG:0]   w_en;
    logic [NSTG-1:0] w_vin;

    // stage logic
    qalu_decode u_decode (
        .i_kind (i_in.kind),
        .i_a    (i_in.operand_a),
        .i_b    (i_in.operand_b),
        .o_itm  (n_itm[0])
    );

    qalu_mul u_mul (
        .i_itm (r_itm[0]),
        .o_itm (n_itm[1])
    );

    for (genvar k = 2; k < NSTG; k++) begin : g_div
        qalu_div_step u_step (
            .i_itm (r_itm[k-1]),
            .o_itm (n_itm[k])
        );
    end

    qalu_round u_round (
        .i_itm (r_itm[NSTG-1]),
        .o_res (n_res)
    );

    // per-stage advance: a stage loads when empty or when its successor moves
    assign w_en[NSTG] = !r_out_vld || o_out.ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end
    assign w_vin = {r_vld[NSTG-2:0], i_in.valid};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
            if (w_en[NSTG]) begin
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_itm[k] <= n_itm[k];
            end
        end
        if (w_en[NSTG]) begin
            r_out <= n_res;
        end
    end

    // ports
    assign i_in.ready           = w_en[0];
    assign o_out.valid          = r_out_vld;
    assign o_out.value          = r_out.value;
    assign o_out.a_greater      = r_out.gt;
    assign o_out.a_less         = r_out.lt;
    assign o_out.a_equal        = r_out.eq;
    assign o_out.overflow       = r_out.ov;
    assign o_out.divide_by_zero = r_out.dz;

`ifndef SYNTH
    // exactly one compare outcome per result
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot({r_out.gt, r_out.lt, r_out.eq}))
        else $error("compare flags not one-hot");

    // divide by zero never also reports overflow
    a_dz_no_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.dz) |-> !r_out.ov)
        else $error("divide by zero with overflow");

    // input stalls only when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en[0] |-> (r_out_vld && !o_out.ready && r_vld[0] && r_vld[NSTG-1]))
        else $error("input stalled with room in the pipeline");
`endif
endmodule

@@ test/testbench.sv @@
// testbench of the q24.8 fixed-point alu: predicted results checked in order
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qalu_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] value;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        ov;
        logic        dz;
    } alu_result_t;

    // clamp a wide signed value into the word
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic ov);
        if (v > WMAX) begin
            ov = 1'b1;
            return 32'h7fffffff;
        end else if (v < WMIN) begin
            ov = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // expected result of one alu transaction
    function automatic alu_result_t alu_predict(input logic [3:0] kind,
                                                input logic [31:0] a, input logic [31:0] b);
        alu_result_t r;
        logic signed [127:0] sa, sb, p, q, mag, num, den, rem;
        logic neg;
        sa = $signed(a);
        sb = $signed(b);
        r.value = '0;
        r.ov = 1'b0;
        r.dz = 1'b0;
        r.gt = sa > sb;
        r.lt = sa < sb;
        r.eq = sa == sb;
        case (kind)
            K_ADD: r.value = clamp_word(sa + sb, r.ov);
            K_SUB: r.value = clamp_word(sa - sb, r.ov);
            K_MUL: begin
                p = sa * sb;
                neg = p < 0;
                mag = neg ? -p : p;
                mag = (mag + (1 << (F - 1))) >>> F;
                r.value = clamp_word(neg ? -mag : mag, r.ov);
            end
            K_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                    r.value = (sa < 0) ? 32'h80000000 : 32'h7fffffff;
                end else begin
                    neg = (sa < 0) != (sb < 0);
                    num = ((sa < 0) ? -sa : sa) <<< F;
                    den = (sb < 0) ? -sb : sb;
                    q = num / den;
                    rem = num % den;
                    if (2 * rem >= den) q = q + 1;
                    r.value = clamp_word(neg ? -q : q, r.ov);
                end
            end
            K_MIN:   r.value = (sa < sb) ? a : b;
            K_MAX:   r.value = (sa > sb) ? a : b;
            K_INC:   r.value = clamp_word(sa + 1, r.ov);
            K_DEC:   r.value = clamp_word(sa - 1, r.ov);
            K_INT: begin
                mag = ((sa < 0) ? -sa : sa) >>> F;
                r.value = clamp_word((sa < 0) ? -mag : mag, r.ov);
            end
            K_TOFIX: r.value = clamp_word(sa <<< F, r.ov);
            default: r.value = '0;
        endcase
        return r;
    endfunction

    // in-order store of predicted results and their check
    class alu_scoreboard;
        alu_result_t pending[$];
        int          mismatches;

        function void note_input(input logic [3:0] kind, input logic [31:0] a,
                                 input logic [31:0] b);
            pending.push_back(alu_predict(kind, a, b));
        endfunction

        function void check_result(input alu_result_t got);
            alu_result_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h", got.value);
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value || got.gt !== exp_r.gt || got.lt !== exp_r.lt ||
                got.eq !== exp_r.eq || got.ov !== exp_r.ov || got.dz !== exp_r.dz) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp value=%h gt%b lt%b eq%b ov%b dz%b, ",
                              "got value=%h gt%b lt%b eq%b ov%b dz%b"},
                             exp_r.value, exp_r.gt, exp_r.lt, exp_r.eq, exp_r.ov, exp_r.dz,
                             got.value, got.gt, got.lt, got.eq, got.ov, got.dz);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   cycles;
    alu_scoreboard board;

    qalu_in_if  in_ch();
    qalu_out_if out_ch();

    q24_8_fixed_point_alu uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle draw: about 31 in a hundred, none during a calm stretch
    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 31);
    endfunction

    // offer one transaction, with a random gap first, and wait for acceptance
    task automatic send_op(input logic [3:0] kind, input logic [31:0] a, input logic [31:0] b);
        while (take_gap()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(kind, a, b);
    endtask

    // random operand: edges, small values, or anything
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h7fffffff - $urandom_range(3);
            1: return 32'h80000000 + $urandom_range(3);
            2: return $urandom_range(1023) - 512;
            3: return $urandom_range(3) - 1;
            4: return {{16{$urandom_range(1)==1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // output side: random stall, check on each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                board.check_result('{out_ch.value, out_ch.a_greater, out_ch.a_less,
                                     out_ch.a_equal, out_ch.overflow, out_ch.divide_by_zero});
            out_ch.ready <= !take_gap();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [31:0] edge_vals[6];
        board = new();
        cycles = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every kind with extreme operands, special cases
        edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h100, 32'hffffff00};
        for (int k = 0; k < 16; k++)
            send_op(k[3:0], edge_vals[k % 6], edge_vals[(k + 1) % 6]);
        send_op(K_DIV, 32'h100, 32'h0);
        send_op(K_DIV, 32'h80000000, 32'h0);
        send_op(K_DIV, 32'h80000000, 32'hffffffff);
        send_op(K_MIN, 32'h1234, 32'h1234);
        send_op(K_MAX, 32'h1234, 32'h1234);
        send_op(K_INT, 32'hfffffe80, 32'h0);
        send_op(K_MUL, 32'h180, 32'hffffff80);
        send_op(K_DIV, 32'h100, 32'h300);
        in_ch.valid <= 1'b0;

        // sender holds off until the pipeline has drained
        while (board.pending.size() != 0) @(posedge i_clk);

        // random part, with a calm stretch in the middle
        for (int n = 0; n < 1800; n++) begin
            calm = (n >= 800 && n < 1000);
            send_op(($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                              : 4'($urandom_range(9)),
                    pick_operand(), pick_operand());
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
